/* hw/rtl/sfcrc_pkg.sv */
// Shared types, constants and the CRC word update for the flash CRC checker.
`timescale 1ns / 1ps

package sfcrc_pkg;

  // Default pointer width and register reset values
  localparam int ADDR_WIDTH_DEF = 15;
  localparam int START_RESET    = 8192;
  localparam int END_RESET      = 24576;
  localparam int CRC_ADDR_RESET = 24487;

  // CRC-16 polynomial and preset
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;

  // Command codes
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_CALC     = 2'd0;
  localparam logic [1:0] STATUS_OK       = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_START    = 2'd0;
  localparam logic [1:0] REG_END      = 2'd1;
  localparam logic [1:0] REG_CRC_ADDR = 2'd2;

  typedef struct packed {
    logic        command;
    logic [15:0] data_word;
  } sfcrc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        pass_done;
    logic [14:0] next_word_addr;
    logic [15:0] crc_value;
  } sfcrc_out_t;

  // Shift one word into the CRC, MSB first, augmented form
  function automatic logic [15:0] crc_feed_word(input logic [15:0] crc,
                                                input logic [15:0] word);
    logic [15:0] c;
    logic        out_bit;
    c = crc;
    for (int i = 15; i >= 0; i--) begin
      out_bit = c[15];
      c = {c[14:0], word[i]};
      if (out_bit) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/segmented_flash_crc16_checker_top.sv */
// Top level of the segmented flash CRC-16 checker.
// An accepted beat goes to the input register, then on to the result register.
// Throughput: one word per cycle while out_ready drains results, set by the
// combinational 16-bit CRC update between the input and result registers.
// Reset (rst, synchronous): pointer to start address 8192, CRC to 0xFFFF,
// expected CRC to zero, configuration to its reset values, both stages empty.
`timescale 1ns / 1ps

module segmented_flash_crc16_checker_top #(
  parameter int ADDR_WIDTH = sfcrc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [ADDR_WIDTH-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sfcrc_pkg::sfcrc_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sfcrc_pkg::sfcrc_out_t out_data
);
  import sfcrc_pkg::*;

  logic      stage_valid;
  sfcrc_in_t stage_data;
  logic      take;

  // Input register
  sfcrc_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .take        (take),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  // Update and result register
  sfcrc_core #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .stage_valid (stage_valid),
    .stage_data  (stage_data),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

/* hw/rtl/sfcrc_in_stage.sv */
// Input register stage: holds one accepted beat until the core takes it.
`timescale 1ns / 1ps

module sfcrc_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfcrc_pkg::sfcrc_in_t in_data,
  input  logic               take,
  output logic               stage_valid,
  output sfcrc_pkg::sfcrc_in_t stage_data
);
  import sfcrc_pkg::*;

  // Accept a new beat when empty or when the held beat leaves this cycle
  assign in_ready = !stage_valid || take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (take) begin
      stage_valid <= 1'b0;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_data <= in_data;
    end
  end

endmodule

/* hw/rtl/sfcrc_core.sv */
// Checker core: configuration, pass state, CRC update and result register.
`timescale 1ns / 1ps

module sfcrc_core #(
  parameter int ADDR_WIDTH = sfcrc_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [ADDR_WIDTH-1:0] cfg_data,
  input  logic                  stage_valid,
  input  sfcrc_pkg::sfcrc_in_t  stage_data,
  output logic                  take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sfcrc_pkg::sfcrc_out_t out_data
);
  import sfcrc_pkg::*;

  logic [ADDR_WIDTH-1:0] start_addr;
  logic [ADDR_WIDTH-1:0] end_addr;
  logic [ADDR_WIDTH-1:0] crc_addr;

  logic [ADDR_WIDTH-1:0] word_pointer, word_pointer_next;
  logic [15:0]           crc_register, crc_register_next;
  logic [15:0]           expected_crc, expected_crc_next;
  logic [15:0]           crc_base;
  logic [ADDR_WIDTH:0]   ptr_inc;
  logic                  done;
  logic [1:0]            status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= ADDR_WIDTH'(START_RESET);
      end_addr   <= ADDR_WIDTH'(END_RESET);
      crc_addr   <= ADDR_WIDTH'(CRC_ADDR_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START:    start_addr <= cfg_data;
        REG_END:      end_addr   <= cfg_data;
        REG_CRC_ADDR: crc_addr   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance when the result register is free or being drained
  assign take = stage_valid && (!out_valid || out_ready);

  // Work out the pass state after this beat
  always_comb begin
    word_pointer_next = word_pointer;
    crc_register_next = crc_register;
    expected_crc_next = expected_crc;
    crc_base          = crc_register;
    ptr_inc           = {1'b0, word_pointer} + (ADDR_WIDTH+1)'(1);
    done              = 1'b0;
    status            = STATUS_CALC;
    if (stage_data.command == CMD_RESTART) begin
      word_pointer_next = start_addr;
    end else begin
      // Preset at the start word
      if (word_pointer == start_addr) begin
        crc_base          = CRC_PRESET;
        expected_crc_next = 16'h0000;
      end
      // Capture the stored CRC instead of feeding it
      if (word_pointer == crc_addr) begin
        expected_crc_next = stage_data.data_word;
        crc_register_next = crc_base;
      end else begin
        crc_register_next = crc_feed_word(crc_base, stage_data.data_word);
      end
      // End of pass once the next address reaches the end address or overflows
      if (ptr_inc >= {1'b0, end_addr} || ptr_inc[ADDR_WIDTH]) begin
        done              = 1'b1;
        word_pointer_next = start_addr;
        if (expected_crc_next != 16'h0000) begin
          status = (expected_crc_next == crc_register_next) ? STATUS_OK
                                                            : STATUS_MISMATCH;
        end
      end else begin
        word_pointer_next = ptr_inc[ADDR_WIDTH-1:0];
      end
    end
  end

  // Pass state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word_pointer <= ADDR_WIDTH'(START_RESET);
      crc_register <= CRC_PRESET;
      expected_crc <= 16'h0000;
    end else if (take) begin
      word_pointer <= word_pointer_next;
      crc_register <= crc_register_next;
      expected_crc <= expected_crc_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_data.status         <= status;
      out_data.pass_done      <= done;
      out_data.next_word_addr <= 15'(word_pointer_next);
      out_data.crc_value      <= crc_register_next;
    end
  end

endmodule

/* hw/rtl/sfcrc_checker.sv */
// Port-level assertions for the flash CRC checker, bound to the top level.
`timescale 1ns / 1ps

module sfcrc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input sfcrc_pkg::sfcrc_out_t out_data
);
  import sfcrc_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A verdict only comes with the end of a pass
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_CALC |-> out_data.pass_done)
    else $error("status verdict without end of pass");

  // No status code beyond mismatch
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == STATUS_CALC || out_data.status == STATUS_OK ||
                  out_data.status == STATUS_MISMATCH)
    else $error("undefined status code");

  // Both stages are empty just after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind segmented_flash_crc16_checker_top sfcrc_checker u_sfcrc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
